// File: hdl/sdc_pkg.sv
// package for the signed radix digit converter
// control/status structs and fixed constants; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sdc_pkg;

  // radix register
  localparam int unsigned RADIX_W     = 5;
  localparam logic [4:0]  RADIX_RESET = 5'd10;
  localparam logic [4:0]  RADIX_MIN   = 5'd2;
  localparam logic [4:0]  RADIX_MAX   = 5'd16;

  // digit and item kind codes
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam logic        KIND_DIGIT  = 1'b0;
  localparam logic        KIND_SIGN   = 1'b1;

  // dividend bits consumed per divider cycle
  localparam int unsigned STEP_BITS   = 8;

  typedef struct packed {
    logic load;      // capture a new input value
    logic div;       // run one divider step
    logic rd;        // read the next stored digit
    logic dec;       // one digit delivered
    logic sel_sign;  // present the minus-sign item
  } cmd_t;

  typedef struct packed {
    logic step_last; // this divider step ends a digit
    logic q_zero;    // quotient of this digit is zero
    logic neg;       // captured value is negative
    logic cnt_one;   // one digit left to emit
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/sdc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sdc_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/sdc_datapath.sv
// datapath: radix register, magnitude, short-remainder divider, digit counter
// depends on sdc_pkg and sdc_ram
`timescale 1ns / 1ps
`default_nettype none

module sdc_datapath #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      cfg_we_i,
  input  wire logic [sdc_pkg::RADIX_W-1:0]               cfg_wdata_i,
  input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]          value_i,
  input  wire sdc_pkg::cmd_t                             cmd_i,
  output sdc_pkg::sts_t                                  sts_o,
  output logic                                           out_kind_o,
  output logic [sdc_pkg::DIGIT_W-1:0]                    out_digit_o
);

  localparam int unsigned DIV_W  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int unsigned NSTEP  = DIV_W / sdc_pkg::STEP_BITS;
  localparam int unsigned STEP_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int unsigned CNT_W  = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned ADDR_W = $clog2(VALUE_WIDTH);
  localparam int unsigned SB     = sdc_pkg::STEP_BITS;

  logic [sdc_pkg::RADIX_W-1:0] radix_q;
  logic [sdc_pkg::RADIX_W-1:0] base;
  logic [DIV_W-1:0]            w_q, w_d;
  logic [sdc_pkg::DIGIT_W-1:0] rem_q, rem_d;
  logic [STEP_W-1:0]           stp_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        neg_q;
  logic [VALUE_WIDTH-1:0]      raw;
  logic [VALUE_WIDTH-1:0]      mag;
  logic [SB-1:0]               qbits;
  logic [sdc_pkg::RADIX_W-1:0] part;
  logic                        step_last;
  logic [sdc_pkg::DIGIT_W-1:0] rd_digit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= sdc_pkg::RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  // out-of-range radix saturates
  always_comb begin
    if (radix_q < sdc_pkg::RADIX_MIN) begin
      base = sdc_pkg::RADIX_MIN;
    end else if (radix_q > sdc_pkg::RADIX_MAX) begin
      base = sdc_pkg::RADIX_MAX;
    end else begin
      base = radix_q;
    end
  end

  // unsigned magnitude, exact for the most negative value
  assign raw = value_i[VALUE_WIDTH-1:0];
  assign mag = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;

  // long division by the radix, eight dividend bits per cycle
  always_comb begin
    part  = '0;
    qbits = '0;
    rem_d = rem_q;
    for (int k = 0; k < SB; k++) begin
      part = {rem_d, w_q[DIV_W-1-k]};
      if (part >= base) begin
        part     = part - base;
        qbits[SB-1-k] = 1'b1;
      end
      rem_d = part[sdc_pkg::DIGIT_W-1:0];
    end
    w_d = w_q << SB;
    w_d[SB-1:0] = qbits;
  end

  assign step_last = (stp_q == STEP_W'(NSTEP - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stp_q <= '0;
      cnt_q <= '0;
      neg_q <= 1'b0;
    end else if (cmd_i.load) begin
      stp_q <= '0;
      cnt_q <= '0;
      neg_q <= raw[VALUE_WIDTH-1];
    end else if (cmd_i.div) begin
      if (step_last) begin
        stp_q <= '0;
        cnt_q <= cnt_q + CNT_W'(1);
      end else begin
        stp_q <= stp_q + STEP_W'(1);
      end
    end else if (cmd_i.dec) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q   <= DIV_W'(mag);
      rem_q <= '0;
    end else if (cmd_i.div) begin
      w_q   <= w_d;
      rem_q <= step_last ? '0 : rem_d;
    end
  end

  sdc_ram #(
    .WIDTH (sdc_pkg::DIGIT_W),
    .DEPTH (VALUE_WIDTH)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (cmd_i.div & step_last),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (rem_d),
    .re_i    (cmd_i.rd),
    .raddr_i (ADDR_W'(cnt_q - CNT_W'(1))),
    .rdata_o (rd_digit)
  );

  assign sts_o.step_last = step_last;
  assign sts_o.q_zero    = (w_d == '0);
  assign sts_o.neg       = neg_q;
  assign sts_o.cnt_one   = (cnt_q == CNT_W'(1));

  assign out_kind_o  = cmd_i.sel_sign ? sdc_pkg::KIND_SIGN : sdc_pkg::KIND_DIGIT;
  assign out_digit_o = cmd_i.sel_sign ? '0 : rd_digit;

  // digit count never passes the value width
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(VALUE_WIDTH))
    else $error("digit count overflow");

  // a stored digit is always below the radix
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div && step_last) |-> ({1'b0, rem_d} < base))
    else $error("digit not below radix");

endmodule

`default_nettype wire

// File: hdl/sdc_ctrl.sv
// controller: sequences capture, division, sign and digit emission
// depends on sdc_pkg
`timescale 1ns / 1ps
`default_nettype none

module sdc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic               out_last_o,
  input  wire sdc_pkg::sts_t sts_i,
  output sdc_pkg::cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SIGN = 5'b00100,
    ST_RD   = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    out_last_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.step_last && sts_i.q_zero) begin
          state_d = sts_i.neg ? ST_SIGN : ST_RD;
        end
      end
      ST_SIGN: begin
        cmd_o.sel_sign = 1'b1;
        out_valid_o    = 1'b1;
        if (out_ready_i) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        out_last_o  = sts_i.cnt_one;
        if (out_ready_i) begin
          cmd_o.dec = 1'b1;
          state_d   = sts_i.cnt_one ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // no new input while a result is pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input taken while output pending");

  // negative value always emits the sign first
  a_sign_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && sts_i.step_last && sts_i.q_zero && sts_i.neg)
      |=> (state_q == ST_SIGN))
    else $error("sign item skipped");

  // after the last item the block is ready again
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_last_o) |=> in_ready_o)
    else $error("not idle after last item");

endmodule

`default_nettype wire

// File: hdl/signed_radix_digit_converter_top.sv
// channel   dir  signals                                   contents
// s_axis    in   tvalid tready tdata                       tdata: value
// m_axis    out  tvalid tready tdata tuser tlast           tdata: digit, tuser: item_kind
// cfg       in   cfg_we cfg_wdata                          radix
//
// one value at a time: accept, then divide by the radix, eight dividend bits per step,
// keeping each remainder as a digit; then a sign item for a negative value, then each
// digit read from the ram and presented; one short-remainder divider serves all digits
// digits go through a VALUE_WIDTH-deep ram with registered read
// reset clears the controller and sets radix to 10; output stall holds the item
// depends on sdc_pkg, sdc_ctrl, sdc_datapath, sdc_ram
`timescale 1ns / 1ps
`default_nettype none

module signed_radix_digit_converter_top #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [sdc_pkg::RADIX_W-1:0]          cfg_wdata_i,
  input  wire logic                                 s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata_i,   // value
  output logic                                      m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  output logic [sdc_pkg::OUT_TDATA_W-1:0]           m_axis_tdata_o,   // digit, zero pad
  output logic                                      m_axis_tuser_o,   // item_kind
  output logic                                      m_axis_tlast_o
);

  sdc_pkg::cmd_t               cmd;
  sdc_pkg::sts_t               sts;
  logic [sdc_pkg::DIGIT_W-1:0] digit;

  sdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_last_o  (m_axis_tlast_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sdc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .value_i     (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_kind_o  (m_axis_tuser_o),
    .out_digit_o (digit)
  );

  assign m_axis_tdata_o = sdc_pkg::OUT_TDATA_W'(digit);

endmodule

`default_nettype wire
